// File: design/gmgb_pkg.sv
// Package for the grid mass block: transaction payload types, function codes,
// register indexes and the command/status structs between controller and datapath.
// No dependencies.
package gmgb_pkg;

  typedef enum logic [1:0] {
    FN_LOAD = 2'd0,
    FN_READ = 2'd1,
    FN_GRAV = 2'd2,
    FN_EXPL = 2'd3
  } func_e;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DIAM = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAC = 1'b1;

  localparam logic [4:0]  DIAM_RST = 5'd16;
  localparam logic [15:0] FRAC_RST = 16'd6554;

  localparam logic [31:0] BLAST_SHARES = 32'd27;

  typedef struct packed {
    func_e       func;
    logic [3:0]  cell_x;
    logic [3:0]  cell_y;
    logic [3:0]  cell_z;
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [9:0]  pos_z;
    logic [31:0] mass_value;
  } in_t;

  typedef struct packed {
    logic        status;
    logic [31:0] cell_mass;
    logic        moved;
    logic [3:0]  dest_x;
    logic [3:0]  dest_y;
    logic [3:0]  dest_z;
  } out_t;

  typedef struct packed {
    logic capture;
    logic clr_wr;
    logic ctr_rd;
    logic ctr_get;
    logic off_inc;
    logic nbr_rd;
    logic nbr_get;
    logic exp_acc;
    logic mul;
    logic amt;
    logic dst_wr;
    logic ctr_wr;
    logic res_ld;
  } cmd_t;

  typedef struct packed {
    func_e func;
    logic  clr_last;
    logic  div_done;
    logic  oob;
    logic  ctr_zero;
    logic  nbr_in;
    logic  off_center;
    logic  off_last;
    logic  found;
  } stat_t;

endpackage

// File: design/gmgb_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module gmgb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/gmgb_cdiv.sv
// Divider by a constant through reciprocal multiplication, split into a low-half and a high-half step.
// No dependencies.
module gmgb_cdiv #(
  parameter int unsigned W   = 10,
  parameter int unsigned DIV = 10
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         go_i,
  input  logic [W-1:0] dividend_i,
  output logic [W-1:0] quo_o,
  output logic         done_o
);

  // quotient = (x * M) >> K with M = ceil(2^K / DIV), exact for every W-bit x
  localparam int unsigned K   = W + $clog2(DIV);
  localparam int unsigned H   = (W + 1) / 2;
  localparam int unsigned PW  = 2 * W + 2;
  localparam logic [63:0] M64 = ((64'd1 << K) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [PW-1:0] M = PW'(M64);

  logic [W-1:0]  x_q, x_d;
  logic [PW-1:0] acc_q, acc_d;
  logic          hi_q, hi_d;
  logic          busy_q, busy_d;

  // low half of the dividend first, then the high half shifted into place
  always_comb begin
    x_d    = x_q;
    acc_d  = acc_q;
    hi_d   = hi_q;
    busy_d = busy_q;
    if (go_i) begin
      x_d    = dividend_i;
      acc_d  = '0;
      hi_d   = 1'b0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!hi_q) begin
        acc_d = M * PW'(x_q[H-1:0]);
        hi_d  = 1'b1;
      end else begin
        acc_d  = acc_q + ((M * PW'(x_q[W-1:H])) << H);
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      hi_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      hi_q   <= hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    acc_q <= acc_d;
  end

  assign quo_o  = W'(acc_q >> K);
  assign done_o = !busy_q;

endmodule

// File: design/gmgb_ctrl.sv
// Controller state machine: sequences clearing, neighbor scans and writes.
// Depends on gmgb_pkg.
module gmgb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  gmgb_pkg::stat_t stat_i,
  output gmgb_pkg::cmd_t  cmd_o,
  output logic           busy,
  output logic           done_o
);

  typedef enum logic [12:0] {
    S_CLEAR = 13'b0000000000001,
    S_IDLE  = 13'b0000000000010,
    S_DIV   = 13'b0000000000100,
    S_CRD   = 13'b0000000001000,
    S_CGET  = 13'b0000000010000,
    S_NRD   = 13'b0000000100000,
    S_NGET  = 13'b0000001000000,
    S_POST  = 13'b0000010000000,
    S_MUL   = 13'b0000100000000,
    S_AMT   = 13'b0001000000000,
    S_WDST  = 13'b0010000000000,
    S_WCTR  = 13'b0100000000000,
    S_FIN   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  logic   done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          if (stat_i.oob) state_d = S_FIN;
          else if (stat_i.func == gmgb_pkg::FN_LOAD) state_d = S_WCTR;
          else state_d = S_CRD;
        end
      end
      S_CRD: begin
        cmd_o.ctr_rd = 1'b1;
        state_d = S_CGET;
      end
      S_CGET: begin
        cmd_o.ctr_get = 1'b1;
        if (stat_i.func == gmgb_pkg::FN_READ) state_d = S_FIN;
        else if (stat_i.func == gmgb_pkg::FN_GRAV && stat_i.ctr_zero) state_d = S_FIN;
        else state_d = S_NRD;
      end
      S_NRD: begin
        if (stat_i.off_center) begin
          cmd_o.off_inc = 1'b1;
        end else if (!stat_i.nbr_in) begin
          // out-of-grid share lands on the center for a blast
          cmd_o.exp_acc = (stat_i.func == gmgb_pkg::FN_EXPL);
          if (stat_i.off_last) state_d = S_POST;
          else cmd_o.off_inc = 1'b1;
        end else begin
          cmd_o.nbr_rd = 1'b1;
          state_d = S_NGET;
        end
      end
      S_NGET: begin
        cmd_o.nbr_get = 1'b1;
        if (stat_i.off_last) begin
          state_d = S_POST;
        end else begin
          cmd_o.off_inc = 1'b1;
          state_d = S_NRD;
        end
      end
      S_POST: begin
        if (stat_i.func == gmgb_pkg::FN_EXPL) state_d = S_WCTR;
        else if (stat_i.found) state_d = S_MUL;
        else state_d = S_FIN;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_AMT;
      end
      S_AMT: begin
        cmd_o.amt = 1'b1;
        state_d = S_WDST;
      end
      S_WDST: begin
        cmd_o.dst_wr = 1'b1;
        state_d = S_WCTR;
      end
      S_WCTR: begin
        cmd_o.ctr_wr = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        cmd_o.res_ld = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FIN);
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// File: design/gmgb_dpath.sv
// Datapath: config registers, cell memory, blast/position dividers, neighbor
// scan, gravity transfer arithmetic and the result register.
// Depends on gmgb_pkg, gmgb_ram, gmgb_cdiv.
module gmgb_dpath #(
  parameter int unsigned MAX_CELLS   = 16,
  parameter int unsigned LY_PER_CELL = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  gmgb_pkg::in_t                       in_i,
  input  logic                                cfg_we_i,
  input  logic [gmgb_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gmgb_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  gmgb_pkg::cmd_t                      cmd_i,
  output gmgb_pkg::stat_t                     stat_o,
  output gmgb_pkg::out_t                      out_o
);

  localparam int unsigned DEPTH = MAX_CELLS * MAX_CELLS * MAX_CELLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CI    = $clog2(MAX_CELLS);

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [CI-1:0] x, input logic [CI-1:0] y,
                                              input logic [CI-1:0] z);
    return AW'(AW'(x) * AW'(MAX_CELLS * MAX_CELLS) + AW'(y) * AW'(MAX_CELLS) + AW'(z));
  endfunction

  // configuration
  logic [4:0]  diam_q;
  logic [15:0] frac_q;
  logic [6:0]  deff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diam_q <= gmgb_pkg::DIAM_RST;
      frac_q <= gmgb_pkg::FRAC_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gmgb_pkg::CFG_DIAM: diam_q <= cfg_data_i[4:0];
        gmgb_pkg::CFG_FRAC: frac_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign deff = ({2'b0, diam_q} > 7'(MAX_CELLS)) ? 7'(MAX_CELLS) : {2'b0, diam_q};

  // dividers
  logic [9:0]  qx, qy, qz;
  logic [31:0] per;
  logic        dvx, dvy, dvz, dvm;

  gmgb_cdiv #(.W(10), .DIV(LY_PER_CELL)) u_divx (
    .clk_i, .rst_ni, .go_i(cmd_i.capture), .dividend_i(in_i.pos_x), .quo_o(qx), .done_o(dvx));
  gmgb_cdiv #(.W(10), .DIV(LY_PER_CELL)) u_divy (
    .clk_i, .rst_ni, .go_i(cmd_i.capture), .dividend_i(in_i.pos_y), .quo_o(qy), .done_o(dvy));
  gmgb_cdiv #(.W(10), .DIV(LY_PER_CELL)) u_divz (
    .clk_i, .rst_ni, .go_i(cmd_i.capture), .dividend_i(in_i.pos_z), .quo_o(qz), .done_o(dvz));
  gmgb_cdiv #(.W(32), .DIV(gmgb_pkg::BLAST_SHARES)) u_divm (
    .clk_i, .rst_ni, .go_i(cmd_i.capture), .dividend_i(in_i.mass_value), .quo_o(per),
    .done_o(dvm));

  // captured transaction
  gmgb_pkg::func_e func_q;
  logic [3:0]      cx_in_q, cy_in_q, cz_in_q;
  logic [31:0]     mass_q;
  logic [9:0]      cen_x, cen_y, cen_z;
  logic            oob;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q <= gmgb_pkg::FN_LOAD;
    end else if (cmd_i.capture) begin
      func_q <= in_i.func;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cx_in_q <= in_i.cell_x;
      cy_in_q <= in_i.cell_y;
      cz_in_q <= in_i.cell_z;
      mass_q  <= in_i.mass_value;
    end
  end

  always_comb begin
    if (func_q == gmgb_pkg::FN_EXPL) begin
      cen_x = qx;
      cen_y = qy;
      cen_z = qz;
    end else begin
      cen_x = {6'b0, cx_in_q};
      cen_y = {6'b0, cy_in_q};
      cen_z = {6'b0, cz_in_q};
    end
    oob = (cen_x >= {3'b0, deff}) || (cen_y >= {3'b0, deff}) || (cen_z >= {3'b0, deff});
  end

  // neighbor offsets, 0..2 standing for -1..+1, z innermost
  logic [1:0]    ox_q, oy_q, oz_q;
  logic [10:0]   sx, sy, sz;
  logic          inx, iny, inz;
  logic [CI-1:0] nx, ny, nz;
  logic [CI-1:0] ctx, cty, ctz;

  always_comb begin
    sx  = {1'b0, cen_x} + 11'(ox_q);
    sy  = {1'b0, cen_y} + 11'(oy_q);
    sz  = {1'b0, cen_z} + 11'(oz_q);
    inx = (sx != 11'd0) && ((sx - 11'd1) < {4'b0, deff});
    iny = (sy != 11'd0) && ((sy - 11'd1) < {4'b0, deff});
    inz = (sz != 11'd0) && ((sz - 11'd1) < {4'b0, deff});
    nx  = CI'(sx - 11'd1);
    ny  = CI'(sy - 11'd1);
    nz  = CI'(sz - 11'd1);
    ctx = CI'(cen_x);
    cty = CI'(cen_y);
    ctz = CI'(cen_z);
  end

  // scan and arithmetic registers
  logic [AW-1:0] clr_q;
  logic          found_q;
  logic [31:0]   c_q, acc_q, best_q, amt_q;
  logic [47:0]   prod_q;
  logic [CI-1:0] bx_q, by_q, bz_q;
  logic [31:0]   rdata;
  logic          better;

  assign better = rdata > (found_q ? best_q : c_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      found_q <= 1'b0;
      ox_q    <= '0;
      oy_q    <= '0;
      oz_q    <= '0;
    end else begin
      if (cmd_i.clr_wr) clr_q <= clr_q + AW'(1);
      if (cmd_i.ctr_get) begin
        found_q <= 1'b0;
        ox_q    <= '0;
        oy_q    <= '0;
        oz_q    <= '0;
      end else begin
        if (cmd_i.nbr_get && func_q == gmgb_pkg::FN_GRAV && better) found_q <= 1'b1;
        if (cmd_i.off_inc) begin
          if (oz_q == 2'd2) begin
            oz_q <= '0;
            if (oy_q == 2'd2) begin
              oy_q <= '0;
              ox_q <= ox_q + 2'd1;
            end else begin
              oy_q <= oy_q + 2'd1;
            end
          end else begin
            oz_q <= oz_q + 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ctr_get) begin
      c_q   <= rdata;
      acc_q <= rdata;
    end
    if (cmd_i.exp_acc) acc_q <= sat_add(acc_q, per);
    if (cmd_i.nbr_get && func_q == gmgb_pkg::FN_GRAV && better) begin
      best_q <= rdata;
      bx_q   <= nx;
      by_q   <= ny;
      bz_q   <= nz;
    end
    if (cmd_i.mul) prod_q <= {16'b0, best_q - c_q} * {32'b0, frac_q};
    if (cmd_i.amt) amt_q <= (prod_q[47:16] > c_q) ? c_q : prod_q[47:16];
  end

  // memory port
  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata;

  always_comb begin
    we    = cmd_i.clr_wr || cmd_i.dst_wr || cmd_i.ctr_wr ||
            (cmd_i.nbr_get && func_q == gmgb_pkg::FN_EXPL);
    addr  = cell_addr(ctx, cty, ctz);
    wdata = '0;
    if (cmd_i.clr_wr) begin
      addr = clr_q;
    end else if (cmd_i.dst_wr) begin
      addr  = cell_addr(bx_q, by_q, bz_q);
      wdata = sat_add(best_q, amt_q);
    end else if (cmd_i.nbr_rd || cmd_i.nbr_get) begin
      addr  = cell_addr(nx, ny, nz);
      wdata = sat_add(rdata, per);
    end else begin
      case (func_q)
        gmgb_pkg::FN_LOAD: wdata = mass_q;
        gmgb_pkg::FN_GRAV: wdata = c_q - amt_q;
        gmgb_pkg::FN_EXPL: wdata = acc_q;
        default:           wdata = c_q;
      endcase
    end
  end

  gmgb_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk_i,
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // result register
  gmgb_pkg::out_t res_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      res_q <= '0;
      if (oob) begin
        res_q.status <= 1'b1;
      end else begin
        case (func_q)
          gmgb_pkg::FN_LOAD: res_q.cell_mass <= mass_q;
          gmgb_pkg::FN_READ: res_q.cell_mass <= c_q;
          gmgb_pkg::FN_GRAV: begin
            res_q.cell_mass <= found_q ? c_q - amt_q : c_q;
            res_q.moved     <= found_q;
            res_q.dest_x    <= found_q ? 4'(bx_q) : 4'd0;
            res_q.dest_y    <= found_q ? 4'(by_q) : 4'd0;
            res_q.dest_z    <= found_q ? 4'(bz_q) : 4'd0;
          end
          default: res_q.cell_mass <= acc_q;
        endcase
      end
    end
  end

  assign out_o = res_q;

  always_comb begin
    stat_o            = '0;
    stat_o.func       = func_q;
    stat_o.clr_last   = (clr_q == AW'(DEPTH - 1));
    stat_o.div_done   = dvx && dvy && dvz && dvm;
    stat_o.oob        = oob;
    stat_o.ctr_zero   = (rdata == 32'd0);
    stat_o.nbr_in     = inx && iny && inz;
    stat_o.off_center = (ox_q == 2'd1) && (oy_q == 2'd1) && (oz_q == 2'd1);
    stat_o.off_last   = (ox_q == 2'd2) && (oy_q == 2'd2) && (oz_q == 2'd2);
    stat_o.found      = found_q;
  end

endmodule

// File: design/grid_mass_gravity_and_blast.sv
// done_o rises at the end of every transaction: out-of-grid, load, read, gravity (reciprocal
// divide in a low-half and a high-half step, up to 26 neighbor reads on the single memory port,
// transfer math and two writes) and explosion. One transaction at a time: the next one is
// accepted at the edge that ends the done_o cycle. The receiver cannot stall. Reset clears the
// state, configuration and scan-control registers, then sweeps all MAX_CELLS^3 cells of the
// cell memory to zero with busy high.
module grid_mass_gravity_and_blast #(
  parameter int unsigned MAX_CELLS   = 16,
  parameter int unsigned LY_PER_CELL = 10
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  gmgb_pkg::in_t                   in_i,
  output gmgb_pkg::out_t                  out_o,
  output logic                            done_o,
  input  logic                            cfg_we_i,
  input  logic [gmgb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gmgb_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  gmgb_pkg::cmd_t  cmd;
  gmgb_pkg::stat_t stat;

  gmgb_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start,
    .stat_i(stat),
    .cmd_o (cmd),
    .busy,
    .done_o
  );

  gmgb_dpath #(
    .MAX_CELLS  (MAX_CELLS),
    .LY_PER_CELL(LY_PER_CELL)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .in_i,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .cmd_i (cmd),
    .stat_o(stat),
    .out_o
  );

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transaction did not raise busy");
  a_oob_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.status) |-> (out_o.cell_mass == 32'd0 && !out_o.moved))
    else $error("ignored transaction returned data");
`endif

endmodule
